[rtl/brec_pkg.sv]
// brec_pkg: shared types, constants and calendar helpers for the epoch / bcd converter
// used by brec_alu and bcd_rtc_epoch_converter_core; no dependencies
package brec_pkg;

    localparam int unsigned YEAR_W = 12;
    localparam int unsigned DAYS_W = 25;

    localparam logic [31:0]       SECS_DAY   = 32'd86400;
    localparam logic [31:0]       SECS_HOUR  = 32'd3600;
    localparam logic [31:0]       SECS_MIN   = 32'd60;
    localparam logic [YEAR_W-1:0] BASE_YEAR  = 12'd1970;
    localparam logic [YEAR_W-1:0] CHIP_YEAR0 = 12'd1968;
    localparam logic [YEAR_W-1:0] NOLEAP_CENTURY = 12'd2100;
    localparam logic [3:0]        LAST_MONTH = 4'd12;
    localparam logic [3:0]        LAST_WALK_MONTH = 4'd11;

    // reciprocals for the constant divides, exact over the operand ranges used
    // seconds / 86400 = ((seconds >> 7) * DAY_RECIP) >> 35
    localparam logic [25:0]       DAY_RECIP  = 26'd50903317;
    // seconds of day / 3600 = ((seconds >> 4) * HOUR_RECIP) >> 21
    localparam logic [13:0]       HOUR_RECIP = 14'd9321;
    // seconds of hour / 60 = ((seconds >> 2) * MIN_RECIP) >> 14
    localparam logic [10:0]       MIN_RECIP  = 11'd1093;

    typedef enum logic {
        OP_TO_EPOCH = 1'b0,
        OP_TO_BCD   = 1'b1
    } t_op;

    typedef struct packed {
        logic        operation;
        logic [31:0] epoch_in;
        logic [7:0]  sec_in;
        logic [7:0]  min_in;
        logic [7:0]  hour_in;
        logic [7:0]  date_in;
        logic [7:0]  month_in;
        logic [7:0]  year_in;
    } t_in_word;

    typedef struct packed {
        logic [31:0] epoch_out;
        logic [7:0]  sec_out;
        logic [7:0]  min_out;
        logic [7:0]  hour_out;
        logic [7:0]  date_out;
        logic [7:0]  month_out;
        logic [7:0]  year_out;
    } t_out_word;

    // nibbles above nine are weighted as they stand
    function automatic logic [7:0] from_bcd(input logic [7:0] b);
        return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
    endfunction

    // exact for every year this block can reach (1968 to 2133)
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        return (y[1:0] == 2'b00) && (y != NOLEAP_CENTURY);
    endfunction

    function automatic logic [8:0] year_len(input logic [YEAR_W-1:0] y);
        return is_leap(y) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] month_len(input logic li, input logic [3:0] idx);
        logic [4:0] d;
        case (idx)
            4'd1:                      d = li ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    function automatic logic [7:0] to_bcd(input logic [6:0] d);
        logic [14:0] p;
        logic [3:0]  tens;
        logic [6:0]  ones;
        p    = 15'(d) * 15'd205;
        tens = p[14:11];
        ones = d - 7'({tens, 3'b000} + {tens, 1'b0});
        return {tens, ones[3:0]};
    endfunction

endpackage

[rtl/bcd_rtc_epoch_converter_core.sv]
// bcd_rtc_epoch_converter_core: epoch seconds <-> bcd clock registers, one word at a time.
// bcd to epoch walks the years from 1970 up to the given one and the months before the given
// one; epoch to bcd walks the elapsed years and months. the year and month walks and the
// shift-add multiply run on the shared adder (brec_alu); o_in_ready high only in idle, next
// word taken in the cycle after the result is registered, later while the previous result
// waits. synchronous active-low reset clears state and out valid.
// depends on brec_pkg and brec_alu
module bcd_rtc_epoch_converter_core
    import brec_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_YEAR0,
        S_MON0,
        S_DATE,
        S_MUL,
        S_DIVD,
        S_REMD,
        S_DIVH,
        S_REMH,
        S_DIVM,
        S_REMM,
        S_YEAR1,
        S_MON1,
        S_DONE
    } t_state;

    t_state              r_state;
    logic                r_op;
    logic [31:0]         r_acc;
    logic [DAYS_W-1:0]   r_days;
    logic [7:0]          r_sec;
    logic [7:0]          r_min;
    logic [7:0]          r_hour;
    logic [7:0]          r_mday;
    logic [3:0]          r_mon;
    logic [3:0]          r_m;
    logic [YEAR_W-1:0]   r_y;
    logic [YEAR_W-1:0]   r_tyear;
    logic                r_li;
    logic [3:0]          r_k;
    logic                r_out_valid;
    t_out_word           r_out;

    logic [31:0]         w_b;
    logic                w_sub;
    logic [31:0]         w_res;
    logic                w_carry;
    logic [7:0]          w_dmon;
    logic [YEAR_W-1:0]   w_tyear;
    logic [31:0]         w_d;
    logic [31:0]         w_h;
    logic [31:0]         w_mi;
    logic [8:0]          w_mday_m1;
    logic [7:0]          w_yoff;
    logic [7:0]          w_yoff_mod;
    logic [50:0]         w_pday;
    logic [25:0]         w_phour;
    logic [19:0]         w_pmin;
    logic [15:0]         w_qday;
    logic [4:0]          w_qhour;
    logic [5:0]          w_qmin;

    brec_alu u_alu (
        .i_a     (r_acc),
        .i_b     (w_b),
        .i_sub   (w_sub),
        .o_res   (w_res),
        .o_carry (w_carry)
    );

    assign w_dmon     = from_bcd(i_in_data.month_in);
    assign w_tyear    = YEAR_W'(from_bcd(i_in_data.year_in)) + CHIP_YEAR0;
    assign w_d        = {7'd0, r_days};
    assign w_h        = {24'd0, r_hour};
    assign w_mi       = {24'd0, r_min};
    assign w_mday_m1  = {1'b0, r_mday} - 9'd1;
    assign w_yoff     = 8'(r_y - CHIP_YEAR0);
    assign w_yoff_mod = (w_yoff >= 8'd100) ? (w_yoff - 8'd100) : w_yoff;

    // quotients by reciprocal multiplication
    assign w_pday  = 51'(r_acc[31:7]) * 51'(DAY_RECIP);
    assign w_phour = 26'(r_acc[16:4]) * 26'(HOUR_RECIP);
    assign w_pmin  = 20'(r_acc[11:2]) * 20'(MIN_RECIP);
    assign w_qday  = w_pday[50:35];
    assign w_qhour = w_phour[25:21];
    assign w_qmin  = w_pmin[19:14];

    // operand select for the shared adder
    always_comb begin
        w_b   = '0;
        w_sub = 1'b0;
        case (r_state)
            S_YEAR0: w_b = {23'd0, year_len(r_y)};
            S_MON0:  w_b = {27'd0, month_len(r_li, r_m - 4'd1)};
            S_DATE:  w_b = {{23{w_mday_m1[8]}}, w_mday_m1};
            S_MUL: begin
                case (r_k)
                    4'd0:    w_b = w_d << 16;
                    4'd1:    w_b = w_d << 14;
                    4'd2:    w_b = w_d << 12;
                    4'd3:    w_b = w_d << 8;
                    4'd4:    w_b = w_d << 7;
                    4'd5:    w_b = w_h << 11;
                    4'd6:    w_b = w_h << 10;
                    4'd7:    w_b = w_h << 9;
                    4'd8:    w_b = w_h << 4;
                    4'd9:    w_b = w_mi << 5;
                    4'd10:   w_b = w_mi << 4;
                    4'd11:   w_b = w_mi << 3;
                    4'd12:   w_b = w_mi << 2;
                    default: w_b = {24'd0, r_sec};
                endcase
            end
            S_REMD: begin
                w_b   = w_d * SECS_DAY;
                w_sub = 1'b1;
            end
            S_REMH: begin
                w_b   = w_h * SECS_HOUR;
                w_sub = 1'b1;
            end
            S_REMM: begin
                w_b   = w_mi * SECS_MIN;
                w_sub = 1'b1;
            end
            S_YEAR1: begin
                w_b   = {23'd0, year_len(r_y)};
                w_sub = 1'b1;
            end
            S_MON1: begin
                w_b   = {27'd0, month_len(r_li, r_m)};
                w_sub = 1'b1;
            end
            default: begin
                w_b   = '0;
                w_sub = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_in_data.operation;
                        r_sec   <= from_bcd(i_in_data.sec_in);
                        r_mday  <= from_bcd(i_in_data.date_in);
                        r_mon   <= (w_dmon > 8'(LAST_MONTH)) ? LAST_MONTH : w_dmon[3:0];
                        r_tyear <= w_tyear;
                        r_li    <= is_leap(w_tyear);
                        r_y     <= BASE_YEAR;
                        r_days  <= '0;
                        if (i_in_data.operation == OP_TO_BCD) begin
                            r_acc   <= i_in_data.epoch_in;
                            r_min   <= '0;
                            r_hour  <= '0;
                            r_m     <= 4'd0;
                            r_k     <= 4'd0;
                            r_state <= S_DIVD;
                        end else begin
                            r_acc   <= '0;
                            r_min   <= from_bcd(i_in_data.min_in);
                            r_hour  <= from_bcd(i_in_data.hour_in);
                            r_m     <= 4'd1;
                            r_k     <= 4'd0;
                            r_state <= S_YEAR0;
                        end
                    end
                end
                S_YEAR0: begin
                    if (r_y < r_tyear) begin
                        r_acc <= w_res;
                        r_y   <= r_y + 12'd1;
                    end else begin
                        r_state <= S_MON0;
                    end
                end
                S_MON0: begin
                    if (r_m < r_mon) begin
                        r_acc <= w_res;
                        r_m   <= r_m + 4'd1;
                    end else begin
                        r_state <= S_DATE;
                    end
                end
                S_DATE: begin
                    r_days  <= w_res[DAYS_W-1:0];
                    r_acc   <= '0;
                    r_k     <= 4'd0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_acc <= w_res;
                    r_k   <= r_k + 4'd1;
                    if (r_k == 4'd13) begin
                        r_state <= S_DONE;
                    end
                end
                S_DIVD: begin
                    r_days  <= {9'd0, w_qday};
                    r_state <= S_REMD;
                end
                S_REMD: begin
                    r_acc   <= w_res;
                    r_state <= S_DIVH;
                end
                S_DIVH: begin
                    r_hour  <= {3'd0, w_qhour};
                    r_state <= S_REMH;
                end
                S_REMH: begin
                    r_acc   <= w_res;
                    r_state <= S_DIVM;
                end
                S_DIVM: begin
                    r_min   <= {2'd0, w_qmin};
                    r_state <= S_REMM;
                end
                S_REMM: begin
                    r_sec   <= {2'b00, w_res[5:0]};
                    r_acc   <= {7'd0, r_days};
                    r_state <= S_YEAR1;
                end
                S_YEAR1: begin
                    if (w_carry) begin
                        r_acc <= w_res;
                        r_y   <= r_y + 12'd1;
                    end else begin
                        r_li    <= is_leap(r_y);
                        r_state <= S_MON1;
                    end
                end
                S_MON1: begin
                    if (r_m < LAST_WALK_MONTH && w_carry) begin
                        r_acc <= w_res;
                        r_m   <= r_m + 4'd1;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_op == OP_TO_BCD) begin
                            r_out.epoch_out <= '0;
                            r_out.sec_out   <= to_bcd(r_sec[6:0]);
                            r_out.min_out   <= to_bcd(r_min[6:0]);
                            r_out.hour_out  <= to_bcd(r_hour[6:0]);
                            r_out.date_out  <= to_bcd({2'b00, r_acc[4:0]} + 7'd1);
                            r_out.month_out <= to_bcd({3'b000, r_m} + 7'd1);
                            r_out.year_out  <= to_bcd(w_yoff_mod[6:0]);
                        end else begin
                            r_out.epoch_out <= r_acc;
                            r_out.sec_out   <= '0;
                            r_out.min_out   <= '0;
                            r_out.hour_out  <= '0;
                            r_out.date_out  <= '0;
                            r_out.month_out <= '0;
                            r_out.year_out  <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready did not drop after a word was taken");

    a_bcd_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.sec_out[3:0] <= 4'd9) && (o_out_data.min_out[3:0] <= 4'd9)
            && (o_out_data.hour_out[3:0] <= 4'd9) && (o_out_data.date_out[3:0] <= 4'd9)
            && (o_out_data.month_out <= 8'h12) && (o_out_data.year_out[3:0] <= 4'd9))
        else $error("result holds a non-decimal digit");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MON0 || r_state == S_MON1) |-> (r_m <= LAST_MONTH))
        else $error("month walk ran past december");

    a_hold_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && r_out_valid && !i_out_ready |=> (r_state == S_DONE))
        else $error("result overwrote a word still waiting");

endmodule

[rtl/brec_alu.sv]
// brec_alu: the one 32-bit add / subtract unit shared by the walk, multiply and remainder steps of the converter
// depends on brec_pkg
module brec_alu
    import brec_pkg::*;
(
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic        i_sub,
    output logic [31:0] o_res,
    output logic        o_carry
);

    logic [32:0] w_sum;

    // on subtract the carry out means a >= b
    assign w_sum   = {1'b0, i_a} + {1'b0, i_b ^ {32{i_sub}}} + {32'd0, i_sub};
    assign o_res   = w_sum[31:0];
    assign o_carry = w_sum[32];

endmodule

[dv/brec_conversion_checker.sv]
// brec_conversion_checker: watches both channels of the epoch / bcd converter, predicts each
// result word from the accepted input word and compares it field by field
// depends on brec_pkg for the word types and operation codes
module brec_conversion_checker
    import brec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_word    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_word   i_out_data,
    output int unsigned o_fail_count,
    output int unsigned o_pending,
    output int unsigned o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SEC_PER_DAY  = 86400;
    localparam int unsigned SEC_PER_HOUR = 3600;
    localparam int unsigned SEC_PER_MIN  = 60;
    localparam int unsigned UNIX_YEAR    = 1970;
    localparam int unsigned CHIP_YEAR    = 1968;

    t_out_word expected_results[$];

    function automatic bit leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_year(input int unsigned y);
        return leap(y) ? 366 : 365;
    endfunction

    // idx counts from zero, january first
    function automatic int unsigned month_length(input bit li, input int unsigned idx);
        int unsigned d;
        case (idx)
            1:          d = li ? 29 : 28;
            3, 5, 8, 10: d = 30;
            default:    d = 31;
        endcase
        return d;
    endfunction

    function automatic int unsigned bcd_value(input logic [7:0] b);
        return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function automatic logic [7:0] bcd_byte(input int unsigned d);
        return 8'(((d / 10) << 4) + d % 10);
    endfunction

    function automatic t_out_word convert_word(input t_in_word w);
        t_out_word    r;
        int unsigned  cal_year, mon, days, rem, y, m;
        bit           li;
        r = '0;
        if (w.operation == OP_TO_EPOCH) begin
            cal_year = bcd_value(w.year_in) + CHIP_YEAR;
            days = 0;
            for (y = UNIX_YEAR; y < cal_year; y++)
                days += days_in_year(y);
            li  = leap(cal_year);
            mon = bcd_value(w.month_in);
            if (mon > 12)
                mon = 12;
            for (m = 1; m < mon; m++)
                days += month_length(li, m - 1);
            days += bcd_value(w.date_in) - 1;
            r.epoch_out = days * SEC_PER_DAY + bcd_value(w.hour_in) * SEC_PER_HOUR
                        + bcd_value(w.min_in) * SEC_PER_MIN + bcd_value(w.sec_in);
        end else begin
            days = w.epoch_in / SEC_PER_DAY;
            rem  = w.epoch_in % SEC_PER_DAY;
            r.hour_out = bcd_byte(rem / SEC_PER_HOUR);
            rem = rem % SEC_PER_HOUR;
            r.min_out = bcd_byte(rem / SEC_PER_MIN);
            r.sec_out = bcd_byte(rem % SEC_PER_MIN);
            y = UNIX_YEAR;
            while (days >= days_in_year(y)) begin
                days -= days_in_year(y);
                y++;
            end
            li = leap(y);
            m = 0;
            while (m < 11 && days >= month_length(li, m)) begin
                days -= month_length(li, m);
                m++;
            end
            r.date_out  = bcd_byte(days + 1);
            r.month_out = bcd_byte(m + 1);
            r.year_out  = bcd_byte((y - CHIP_YEAR) % 100);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        o_fail_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                expected_results.push_back(convert_word(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result word %h with nothing expected",
                                              i_out_data));
                end else begin
                    want = expected_results.pop_front();
                    check_field("epoch_out", i_out_data.epoch_out, want.epoch_out);
                    check_field("sec_out",   i_out_data.sec_out,   want.sec_out);
                    check_field("min_out",   i_out_data.min_out,   want.min_out);
                    check_field("hour_out",  i_out_data.hour_out,  want.hour_out);
                    check_field("date_out",  i_out_data.date_out,  want.date_out);
                    check_field("month_out", i_out_data.month_out, want.month_out);
                    check_field("year_out",  i_out_data.year_out,  want.year_out);
                    o_checked <= o_checked + 1;
                end
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

[dv/tb_bcd_rtc_epoch_converter_core.sv]
// tb_bcd_rtc_epoch_converter_core: drives directed and random conversion words through the
// converter under several idle and stall patterns and a long output hold-off
// depends on brec_pkg, bcd_rtc_epoch_converter_core and brec_conversion_checker
module tb_bcd_rtc_epoch_converter_core
    import brec_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HALF_PERIOD    = 5;
    localparam int unsigned PHASE_WORDS    = 360;
    localparam int unsigned PRESSURE_WORDS = 12;
    localparam int unsigned HOLD_OFF_CYCLES = 600;
    localparam int unsigned DRAIN_CYCLES   = 250;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam logic [31:0] EPOCH_LAST     = 32'd3092601599;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_word out_word;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_off_req   = 1'b0;
    int unsigned n_to_epoch     = 0;
    int unsigned n_to_bcd       = 0;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;

    bcd_rtc_epoch_converter_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_word)
    );

    brec_conversion_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic logic [7:0] to_bcd_byte(input int unsigned d);
        return 8'(((d / 10) << 4) + d % 10);
    endfunction

    function automatic t_in_word chip_regs_word(input logic [7:0] yr, input logic [7:0] mo,
                                                input logic [7:0] dt, input logic [7:0] hr,
                                                input logic [7:0] mi, input logic [7:0] se);
        t_in_word w;
        w.operation = OP_TO_EPOCH;
        w.epoch_in  = $urandom();
        w.year_in   = yr;
        w.month_in  = mo;
        w.date_in   = dt;
        w.hour_in   = hr;
        w.min_in    = mi;
        w.sec_in    = se;
        return w;
    endfunction

    function automatic t_in_word epoch_word(input logic [31:0] e);
        t_in_word w;
        w = chip_regs_word(8'($urandom()), 8'($urandom()), 8'($urandom()),
                           8'($urandom()), 8'($urandom()), 8'($urandom()));
        w.operation = OP_TO_BCD;
        w.epoch_in  = e;
        return w;
    endfunction

    // mostly plausible calendar values, some raw bytes and full-range seconds
    function automatic t_in_word random_word();
        t_in_word w;
        if ($urandom_range(1) == 0) begin
            w = chip_regs_word(8'($urandom()), 8'($urandom()), 8'($urandom()),
                               8'($urandom()), 8'($urandom()), 8'($urandom()));
            if ($urandom_range(9) < 7) begin
                w.year_in  = to_bcd_byte($urandom_range(99));
                w.month_in = to_bcd_byte($urandom_range(12, 1));
                w.date_in  = to_bcd_byte($urandom_range(31, 1));
                w.hour_in  = to_bcd_byte($urandom_range(23));
                w.min_in   = to_bcd_byte($urandom_range(59));
                w.sec_in   = to_bcd_byte($urandom_range(59));
            end
        end else begin
            if ($urandom_range(9) < 8)
                w = epoch_word($urandom_range(EPOCH_LAST));
            else
                w = epoch_word($urandom());
        end
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        if (w.operation == OP_TO_EPOCH)
            n_to_epoch++;
        else
            n_to_bcd++;
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count) send_word(random_word());
    endtask

    initial begin
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // chip registers to seconds
        send_word(chip_regs_word(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_word(chip_regs_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_word(chip_regs_word(8'h02, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00));
        send_word(chip_regs_word(8'h01, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59));
        send_word(chip_regs_word(8'h00, 8'h03, 8'h01, 8'h12, 8'h30, 8'h00));
        send_word(chip_regs_word(8'h32, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00));
        send_word(chip_regs_word(8'hD2, 8'h03, 8'h01, 8'h00, 8'h00, 8'h01));
        send_word(chip_regs_word(8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59));
        send_word(chip_regs_word(8'h50, 8'h13, 8'h15, 8'h06, 8'h07, 8'h08));
        send_word(chip_regs_word(8'h55, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_word(chip_regs_word(8'h9A, 8'h0F, 8'hA0, 8'h0F, 8'hF0, 8'h5A));
        // seconds to chip registers
        send_word(epoch_word(32'd0));
        send_word(epoch_word(32'd86399));
        send_word(epoch_word(32'd68169600));
        send_word(epoch_word(32'd951782400));
        send_word(epoch_word(32'd951868800));
        send_word(epoch_word(EPOCH_LAST));
        send_word(epoch_word(EPOCH_LAST + 32'd1));
        send_word(epoch_word(32'd4107542400));
        send_word(epoch_word(32'hFFFFFFFF));
        send_word(epoch_word(32'h7FFFFFFF));

        send_random(PHASE_WORDS);
        send_idle_pct = 83;
        send_random(PHASE_WORDS);
        send_idle_pct  = 0;
        recv_stall_pct = 83;
        send_random(PHASE_WORDS);
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        send_random(PHASE_WORDS);

        // output held off while words keep coming, so the input stalls
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 1'b1;
        send_random(PRESSURE_WORDS);
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d register-to-seconds and %0d seconds-to-register words, %0d compared",
                 n_to_epoch, n_to_bcd, checked);
        $display("phases: free flow, sparse input, stalled output, light mix, long output hold");
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/brec_pkg.sv
rtl/brec_alu.sv
rtl/bcd_rtc_epoch_converter_core.sv
dv/brec_conversion_checker.sv
dv/tb_bcd_rtc_epoch_converter_core.sv
